>>> hdl/tlbsc_pkg.sv
package tlbsc_pkg;

    localparam int INDEX_BITS  = 4;
    localparam int PAGE_BITS   = 20;
    localparam int FRAME_BITS  = 20;
    localparam int ENTRIES     = 1 << INDEX_BITS;

    localparam int OFFSET_BITS = 16;
    localparam int ADDR_BITS   = 36;
    localparam int SLOT_BITS   = 4;
    localparam int SHIFT_BITS  = 5;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 5'd12;

    // broadcast to every cell for the access in flight
    typedef struct packed {
        logic                  acc;
        logic                  wr;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] walk;
        logic                  any_hit;
        logic                  any_inv;
        logic                  any_unused;
    } ctl_t;

    // rippled from cell i to cell i+1
    typedef struct packed {
        logic                  hit;
        logic                  inv;
        logic                  unused;
        logic [INDEX_BITS-1:0] slot;
        logic [FRAME_BITS-1:0] frame;
    } chain_t;

    typedef struct packed {
        logic hit_sel;
        logic victim;
        logic valid;
    } stat_t;

endpackage

>>> hdl/tlb_lookup_second_chance.sv
// The result of an accepted word is registered in the output register.
// Throughput: one word per cycle while the output register is empty or being taken;
// lookup, victim choice and sweep ripple along the row of 16 entry cells within the accepting cycle.
// in_ready stays high while the output register is empty or being taken.
// Reset (rst_n, async, low) clears valid/used/dirty bits and the output valid,
// and sets page_shift to 12; page and frame storage is not reset.
module tlb_lookup_second_chance (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tlbsc_pkg::SHIFT_BITS-1:0]  cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tlbsc_pkg::PAGE_BITS-1:0]   virt_page,
    input  logic [tlbsc_pkg::OFFSET_BITS-1:0] page_offset,
    input  logic                              is_write,
    input  logic [tlbsc_pkg::FRAME_BITS-1:0]  walk_frame,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tlbsc_pkg::ADDR_BITS-1:0]   phys_addr,
    output logic                              hit,
    output logic [tlbsc_pkg::SLOT_BITS-1:0]   slot,
    output logic                              pt_mark_dirty,
    output logic                              pt_count_use
);

    logic [tlbsc_pkg::SHIFT_BITS-1:0] page_shift_reg;
    logic                             out_valid_reg, out_valid_next;
    logic [tlbsc_pkg::ADDR_BITS-1:0]  phys_addr_reg, phys_addr_next;
    logic                             hit_reg;
    logic [tlbsc_pkg::SLOT_BITS-1:0]  slot_reg, slot_next;
    logic                             dirty_reg;

    logic                             acc;
    tlbsc_pkg::ctl_t                  ctl;
    tlbsc_pkg::chain_t                chain [tlbsc_pkg::ENTRIES+1];
    tlbsc_pkg::stat_t                 stat  [tlbsc_pkg::ENTRIES];
    logic [tlbsc_pkg::ENTRIES-1:0]    hit_vec;
    logic [tlbsc_pkg::ENTRIES-1:0]    victim_vec;
    logic [tlbsc_pkg::ENTRIES-1:0]    valid_vec;
    logic [tlbsc_pkg::FRAME_BITS-1:0] frame;

    assign in_ready = !out_valid_reg || out_ready;
    assign acc      = in_valid && in_ready;

    assign chain[0] = '0;

    always_comb
    begin
        ctl.acc        = acc;
        ctl.wr         = is_write;
        ctl.page       = virt_page;
        ctl.walk       = walk_frame;
        ctl.any_hit    = chain[tlbsc_pkg::ENTRIES].hit;
        ctl.any_inv    = chain[tlbsc_pkg::ENTRIES].inv;
        ctl.any_unused = chain[tlbsc_pkg::ENTRIES].unused;
    end

    for (genvar i = 0; i < tlbsc_pkg::ENTRIES; i++)
    begin : g_cell
        tlbsc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (tlbsc_pkg::INDEX_BITS'(i)),
            .ctl       (ctl),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .stat      (stat[i])
        );
        assign hit_vec[i]    = stat[i].hit_sel;
        assign victim_vec[i] = stat[i].victim;
        assign valid_vec[i]  = stat[i].valid;
    end

    assign frame = ctl.any_hit ? chain[tlbsc_pkg::ENTRIES].frame : walk_frame;

    assign phys_addr_next = (tlbsc_pkg::ADDR_BITS'(frame) << page_shift_reg)
                          | tlbsc_pkg::ADDR_BITS'(page_offset);
    assign slot_next      = tlbsc_pkg::SLOT_BITS'(chain[tlbsc_pkg::ENTRIES].slot);
    assign out_valid_next = acc || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg <= tlbsc_pkg::SHIFT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                page_shift_reg <= cfg_wdata;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            phys_addr_reg <= phys_addr_next;
            hit_reg       <= ctl.any_hit;
            slot_reg      <= slot_next;
            dirty_reg     <= is_write;
        end
    end

    assign out_valid     = out_valid_reg;
    assign phys_addr     = phys_addr_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign pt_mark_dirty = dirty_reg;
    assign pt_count_use  = hit_reg;

    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one entry selected as hit");

    a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !ctl.any_hit) |-> $onehot(victim_vec))
        else $error("miss without exactly one victim");

    a_no_victim_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.any_hit |-> (victim_vec == '0))
        else $error("victim chosen on a hit");

    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !ctl.any_hit) |=> (valid_vec == ($past(valid_vec) | $past(victim_vec))))
        else $error("filled entry not valid after miss");

endmodule

>>> hdl/tlbsc_cell.sv
module tlbsc_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tlbsc_pkg::INDEX_BITS-1:0] idx,
    input  tlbsc_pkg::ctl_t                 ctl,
    input  tlbsc_pkg::chain_t               chain_in,
    output tlbsc_pkg::chain_t               chain_out,
    output tlbsc_pkg::stat_t                stat
);

    logic                             valid_reg, valid_next;
    logic                             used_reg, used_next;
    logic                             dirty_reg, dirty_next;
    logic [tlbsc_pkg::PAGE_BITS-1:0]  page_reg;
    logic [tlbsc_pkg::FRAME_BITS-1:0] frame_reg;

    logic match;
    logic hit_sel;
    logic inv_sel;
    logic unused_sel;
    logic victim;
    logic swept;

    assign match      = valid_reg && (page_reg == ctl.page);
    assign hit_sel    = match && !chain_in.hit;
    assign inv_sel    = !valid_reg && !chain_in.inv;
    assign unused_sel = !used_reg && !chain_in.unused;

    // no free entry: first clear used bit wins, else entry 0
    always_comb
    begin
        victim = 1'b0;
        if (!ctl.any_hit)
        begin
            priority if (ctl.any_inv)
                victim = inv_sel;
            else if (ctl.any_unused)
                victim = unused_sel;
            else
                victim = (idx == '0);
        end
    end

    // cells ahead of the first clear used bit lose their second chance
    assign swept = !ctl.any_hit && !ctl.any_inv && !chain_in.unused;

    always_comb
    begin
        chain_out.hit    = chain_in.hit | match;
        chain_out.inv    = chain_in.inv | !valid_reg;
        chain_out.unused = chain_in.unused | !used_reg;
        chain_out.slot   = chain_in.slot | ((hit_sel || victim) ? idx : '0);
        chain_out.frame  = chain_in.frame | (hit_sel ? frame_reg : '0);
    end

    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        dirty_next = dirty_reg;
        if (ctl.acc)
        begin
            priority if (hit_sel)
            begin
                used_next = 1'b1;
                if (ctl.wr)
                    dirty_next = 1'b1;
            end
            else if (victim)
            begin
                valid_next = 1'b1;
                used_next  = 1'b1;
                dirty_next = ctl.wr;
            end
            else if (swept)
                used_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            used_reg  <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.acc && victim)
        begin
            page_reg  <= ctl.page;
            frame_reg <= ctl.walk;
        end
    end

    assign stat.hit_sel = hit_sel;
    assign stat.victim  = victim;
    assign stat.valid   = valid_reg;

endmodule

>>> tb/sv/tb_tlb_lookup_second_chance.sv
module tb_tlb_lookup_second_chance;

    localparam int INDEX_BITS  = tlbsc_pkg::INDEX_BITS;
    localparam int PAGE_BITS   = tlbsc_pkg::PAGE_BITS;
    localparam int FRAME_BITS  = tlbsc_pkg::FRAME_BITS;
    localparam int ENTRIES     = tlbsc_pkg::ENTRIES;
    localparam int OFFSET_BITS = tlbsc_pkg::OFFSET_BITS;
    localparam int ADDR_BITS   = tlbsc_pkg::ADDR_BITS;
    localparam int SLOT_BITS   = tlbsc_pkg::SLOT_BITS;
    localparam int SHIFT_BITS  = tlbsc_pkg::SHIFT_BITS;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = tlbsc_pkg::SHIFT_RESET;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOT_MAX     = 24;

    typedef struct packed {
        logic [ADDR_BITS-1:0] phys;
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
        logic                 mark_dirty;
        logic                 count_use;
    } xlat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [SHIFT_BITS-1:0]  cfg_wdata = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [PAGE_BITS-1:0]   virt_page = '0;
    logic [OFFSET_BITS-1:0] page_offset = '0;
    logic                   is_write = 1'b0;
    logic [FRAME_BITS-1:0]  walk_frame = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [ADDR_BITS-1:0]   phys_addr;
    logic                   hit;
    logic [SLOT_BITS-1:0]   slot;
    logic                   pt_mark_dirty;
    logic                   pt_count_use;

    // predictor's copy of the TLB
    logic                  tlb_valid [ENTRIES];
    logic                  tlb_used  [ENTRIES];
    logic                  tlb_dirty [ENTRIES];
    logic [PAGE_BITS-1:0]  tlb_page  [ENTRIES];
    logic [FRAME_BITS-1:0] tlb_frame [ENTRIES];
    logic [SHIFT_BITS-1:0] cur_shift = SHIFT_RESET;

    xlat_t pending_xlats[$];
    int    n_mismatches = 0;
    int    quiet_cycles = 0;

    logic [PAGE_BITS-1:0] hot_pages [HOT_MAX];
    int    hot_count = HOT_MAX;

    int    rx_stall_pct = 0;
    int    hold_request = 0;
    int    hold_left = 0;
    int    stall_left = 0;

    tlb_lookup_second_chance DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .virt_page     (virt_page),
        .page_offset   (page_offset),
        .is_write      (is_write),
        .walk_frame    (walk_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .phys_addr     (phys_addr),
        .hit           (hit),
        .slot          (slot),
        .pt_mark_dirty (pt_mark_dirty),
        .pt_count_use  (pt_count_use)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic xlat_t translate(input logic [PAGE_BITS-1:0] page,
                                        input logic [OFFSET_BITS-1:0] offs,
                                        input logic wr,
                                        input logic [FRAME_BITS-1:0] walk);
        xlat_t                 r;
        int                    idx;
        logic                  found;
        logic                  picked;
        logic [FRAME_BITS-1:0] frame;
        logic [63:0]           wide;
        found = 1'b0;
        idx   = 0;
        frame = walk;
        for (int i = 0; i < ENTRIES; i++)
            if (!found && tlb_valid[i] && tlb_page[i] == page)
            begin
                found = 1'b1;
                idx   = i;
            end
        if (found)
        begin
            tlb_used[idx] = 1'b1;
            if (wr)
                tlb_dirty[idx] = 1'b1;
            frame = tlb_frame[idx];
        end
        else
        begin
            picked = 1'b0;
            for (int i = 0; i < ENTRIES; i++)
                if (!picked && !tlb_valid[i])
                begin
                    idx    = i;
                    picked = 1'b1;
                end
            // second chance: sweep from entry 0, clearing used bits on the way
            for (int i = 0; i < ENTRIES; i++)
                if (!picked)
                begin
                    if (!tlb_used[i])
                    begin
                        idx    = i;
                        picked = 1'b1;
                    end
                    else
                        tlb_used[i] = 1'b0;
                end
            if (!picked)
                idx = 0;
            tlb_page[idx]  = page;
            tlb_frame[idx] = walk;
            tlb_valid[idx] = 1'b1;
            tlb_used[idx]  = 1'b1;
            tlb_dirty[idx] = wr;
        end
        // offset is ORed in whole, never masked to the page size
        wide = (64'(frame) << cur_shift) | 64'(offs);
        r.phys       = wide[ADDR_BITS-1:0];
        r.hit        = found;
        r.slot       = SLOT_BITS'(idx);
        r.mark_dirty = wr;
        r.count_use  = found;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_BITS-1:0] got,
                                   input logic [ADDR_BITS-1:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
        n_mismatches++;
    endtask

    // watch both channels and the config port on every rising edge
    always @(posedge clk)
    begin
        xlat_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_xlats.size() == 0)
                    report_mismatch("unexpected word", phys_addr, '0);
                else
                begin
                    want = pending_xlats.pop_front();
                    if (phys_addr !== want.phys)
                        report_mismatch("phys_addr", phys_addr, want.phys);
                    if (hit !== want.hit)
                        report_mismatch("hit", ADDR_BITS'(hit), ADDR_BITS'(want.hit));
                    if (slot !== want.slot)
                        report_mismatch("slot", ADDR_BITS'(slot), ADDR_BITS'(want.slot));
                    if (pt_mark_dirty !== want.mark_dirty)
                        report_mismatch("pt_mark_dirty", ADDR_BITS'(pt_mark_dirty),
                                        ADDR_BITS'(want.mark_dirty));
                    if (pt_count_use !== want.count_use)
                        report_mismatch("pt_count_use", ADDR_BITS'(pt_count_use),
                                        ADDR_BITS'(want.count_use));
                end
            end
            if (in_valid && in_ready)
                pending_xlats.push_back(translate(virt_page, page_offset, is_write,
                                                  walk_frame));
            if (cfg_we)
                cur_shift = cfg_wdata;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver: long hold-offs on request, otherwise short random stalls
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct)
        begin
            stall_left = $urandom_range(5);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_word(input logic [PAGE_BITS-1:0] page,
                             input logic [OFFSET_BITS-1:0] offs,
                             input logic wr,
                             input logic [FRAME_BITS-1:0] walk);
        @(negedge clk);
        virt_page   <= page;
        page_offset <= offs;
        is_write    <= wr;
        walk_frame  <= walk;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_random_word();
        logic [PAGE_BITS-1:0] page;
        if ($urandom_range(9) == 0)
            page = PAGE_BITS'($urandom);
        else
            page = hot_pages[$urandom_range(hot_count - 1)];
        send_word(page, OFFSET_BITS'($urandom), 1'($urandom), FRAME_BITS'($urandom));
    endtask

    task automatic drain_results();
        idle_gap(1);
        while (pending_xlats.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_page_shift(input logic [SHIFT_BITS-1:0] shift);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= shift;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // fill every entry, hit on read and write, then exercise the sweep
    task automatic test_fill_and_replace();
        logic [PAGE_BITS-1:0] page;
        for (int i = 0; i < ENTRIES; i++)
        begin
            page = PAGE_BITS'(i * 20'h11111);
            send_word(page, (i % 2 == 0) ? 16'hFFFF : 16'h0000, i[0],
                      FRAME_BITS'(20'hFFFFF - i * 20'h11111));
        end
        send_word(20'h55555, 16'h1234, 1'b0, 20'h00000);
        // walk frame must be ignored on a hit
        send_word(20'h77777, 16'hFFFF, 1'b1, 20'hABCDE);
        // all used bits set: sweep clears them all and takes entry 0
        send_word(20'h12345, 16'h0F0F, 1'b0, 20'h0BEEF);
        send_word(20'h23456, 16'hF0F0, 1'b1, 20'hFFFFF);
        send_word(20'h33333, 16'h0001, 1'b0, 20'h00001);
        send_word(20'h98765, 16'h8000, 1'b1, 20'h80000);
        // page 0 was evicted above
        send_word(20'h00000, 16'hFFFF, 1'b0, 20'h7FFFF);
        drain_results();
    endtask

    task automatic test_random_traffic(input logic [SHIFT_BITS-1:0] shift, input int words,
                                       input int stall_pct, input bit bursty);
        int burst_left;
        burst_left = 0;
        set_page_shift(shift);
        // pool of 8 to 24 pages around the 16-entry TLB so that hits and evictions mix
        hot_count = $urandom_range(8, HOT_MAX);
        foreach (hot_pages[i])
            hot_pages[i] = PAGE_BITS'($urandom);
        rx_stall_pct = stall_pct;
        for (int n = 0; n < words; n++)
        begin
            if (bursty && burst_left == 0)
            begin
                idle_gap($urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
            if (burst_left > 0)
                burst_left--;
            send_random_word();
        end
        drain_results();
        rx_stall_pct = 0;
    endtask

    // receiver holds off while words keep coming, then sender waits for all results
    task automatic test_output_backpressure();
        hold_request = 40;
        for (int n = 0; n < 12; n++)
            send_random_word();
        drain_results();
    endtask

    initial
    begin
        foreach (tlb_valid[i])
        begin
            tlb_valid[i] = 1'b0;
            tlb_used[i]  = 1'b0;
            tlb_dirty[i] = 1'b0;
            tlb_page[i]  = '0;
            tlb_frame[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_fill_and_replace();
        test_random_traffic(5'd12, 120, 0, 1'b0);
        test_output_backpressure();
        test_random_traffic(5'd1, 150, 30, 1'b1);
        test_random_traffic(5'd16, 150, 20, 1'b1);
        test_random_traffic(5'd0, 120, 25, 1'b1);
        test_random_traffic(5'd31, 120, 25, 1'b1);
        test_random_traffic(SHIFT_BITS'($urandom_range(2, 15)), 150, 15, 1'b1);
        test_random_traffic(SHIFT_BITS'($urandom), 150, 35, 1'b1);

        repeat (4) @(posedge clk);
        if (n_mismatches == 0 && pending_xlats.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> tlb_lookup_second_chance.f
hdl/tlbsc_pkg.sv
hdl/tlbsc_cell.sv
hdl/tlb_lookup_second_chance.sv
tb/sv/tb_tlb_lookup_second_chance.sv
